>>> src/ppdrf_pkg.sv
// Shared constants and types for the ping-pong dma ring feeder.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ppdrf_pkg;

   // ring geometry; two slots always stay held by the dma descriptors
   localparam int RING_DEPTH = 8;
   localparam int SLOT_W     = $clog2(RING_DEPTH);
   localparam int COUNT_W    = 4;
   localparam int TOTAL_W    = 32;
   localparam logic [COUNT_W-1:0] FREE_RESET = COUNT_W'(RING_DEPTH - 2);

   // item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_IRQ   = 1'b1;

   // descriptor codes
   localparam logic DESC_A = 1'b0;
   localparam logic DESC_B = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // register the request fields
      logic execute;   // update ring state and the result registers
   } ctrl_cmd_type;

endpackage

>>> src/ppdrf_ctrl.sv
// Controller state machine for the ping-pong dma ring feeder.
// Depends on ppdrf_pkg; drives the command struct into ppdrf_datapath.
`timescale 1ns / 1ps

module ppdrf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   output ppdrf_pkg::ctrl_cmd_type cmd
);
   import ppdrf_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // next state and strobe
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd.capture  = 1'b0;
      cmd.execute  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/ppdrf_datapath.sv
// Ring counters, descriptor choice, underrun counters and result registers.
// Depends on ppdrf_pkg; commanded by ppdrf_ctrl.
`timescale 1ns / 1ps

module ppdrf_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  ppdrf_pkg::ctrl_cmd_type         cmd,
   input  logic                            req_kind,
   input  logic [ppdrf_pkg::COUNT_W-1:0]   req_chunk_count,
   input  logic                            req_status_busy_b,
   input  logic                            req_status_started_a,
   input  logic                            req_status_started_b,
   output logic [ppdrf_pkg::COUNT_W-1:0]   rsp_accepted_chunks,
   output logic                            rsp_first_target,
   output logic                            rsp_first_from_ring,
   output logic [2:0]                      rsp_first_slot,
   output logic                            rsp_second_valid,
   output logic                            rsp_second_from_ring,
   output logic [2:0]                      rsp_second_slot,
   output logic [ppdrf_pkg::TOTAL_W-1:0]   rsp_user_underrun_total,
   output logic [ppdrf_pkg::TOTAL_W-1:0]   rsp_irq_underrun_total,
   output logic [ppdrf_pkg::COUNT_W-1:0]   rsp_high_water,
   output logic [ppdrf_pkg::COUNT_W-1:0]   rsp_queued_chunks
);
   import ppdrf_pkg::*;

   // captured request
   logic               kind_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic               busy_b_ff;
   logic               st_a_ff;
   logic               st_b_ff;

   // ring state
   logic [COUNT_W-1:0] queued_ff, queued_in;
   logic [COUNT_W-1:0] free_ff, free_in;
   logic [SLOT_W-1:0]  head_ff, head_in;
   logic [SLOT_W-1:0]  tail_ff, tail_in;
   logic               good_ff, good_in;
   logic [TOTAL_W-1:0] user_ur_ff, user_ur_in;
   logic [TOTAL_W-1:0] irq_ur_ff, irq_ur_in;
   logic [COUNT_W-1:0] hwm_ff, hwm_in;

   // result registers
   logic [COUNT_W-1:0] acc_ff, acc_in;
   logic               ft_ff, ft_in;
   logic               fr_ff, fr_in;
   logic [SLOT_W-1:0]  fs_ff, fs_in;
   logic               sv_ff, sv_in;
   logic               sr_ff, sr_in;
   logic [SLOT_W-1:0]  ss_ff, ss_in;

   // intermediates
   logic [COUNT_W-1:0] accepted;
   logic [COUNT_W-1:0] q_write;
   logic [SLOT_W:0]    head_sum;
   logic               a_first;
   logic               first_r;
   logic [SLOT_W-1:0]  tail1;
   logic [COUNT_W-1:0] q1;
   logic               sec_v;
   logic               sec_r;
   logic [SLOT_W-1:0]  tail2;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      logic [SLOT_W:0] nxt;
      nxt = {1'b0, s} + 1'b1;
      if (nxt >= (SLOT_W+1)'(RING_DEPTH)) begin
         return '0;
      end
      return nxt[SLOT_W-1:0];
   endfunction

   // write transfer: clip to free slots and advance the head
   always_comb begin
      accepted = (cnt_ff < free_ff) ? cnt_ff : free_ff;
      q_write  = queued_ff + accepted;
      head_sum = {1'b0, head_ff} + (SLOT_W+1)'(accepted);
      if (head_sum >= (SLOT_W+1)'(RING_DEPTH)) begin
         head_sum = head_sum - (SLOT_W+1)'(RING_DEPTH);
      end
   end

   // interrupt transfer: pick descriptors and pull up to two slots
   always_comb begin
      a_first = (busy_b_ff && st_b_ff) || (!busy_b_ff && !st_a_ff);
      first_r = (queued_ff != '0);
      tail1   = first_r ? slot_inc(tail_ff) : tail_ff;
      q1      = queued_ff - COUNT_W'(first_r);
      sec_v   = a_first ? !st_b_ff : !st_a_ff;
      sec_r   = sec_v && (q1 != '0);
      tail2   = sec_r ? slot_inc(tail1) : tail1;
   end

   // next state and result values
   always_comb begin
      queued_in  = queued_ff;
      free_in    = free_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      good_in    = good_ff;
      user_ur_in = user_ur_ff;
      irq_ur_in  = irq_ur_ff;
      hwm_in     = hwm_ff;
      acc_in     = '0;
      ft_in      = DESC_A;
      fr_in      = 1'b0;
      fs_in      = '0;
      sv_in      = 1'b0;
      sr_in      = 1'b0;
      ss_in      = '0;
      case (kind_ff)
         KIND_WRITE: begin
            acc_in    = accepted;
            queued_in = q_write;
            free_in   = free_ff - accepted;
            head_in   = head_sum[SLOT_W-1:0];
            good_in   = 1'b1;
            if (q_write > hwm_ff) begin
               hwm_in = q_write;
            end
         end
         default: begin
            ft_in = a_first ? DESC_A : DESC_B;
            fr_in = first_r;
            fs_in = first_r ? tail_ff : '0;
            if (!first_r && good_ff) begin
               good_in    = 1'b0;
               user_ur_in = user_ur_ff + 1'b1;
            end
            sv_in = sec_v;
            sr_in = sec_r;
            ss_in = sec_r ? tail1 : '0;
            if (sec_v) begin
               irq_ur_in = irq_ur_ff + 1'b1;
            end
            tail_in   = tail2;
            queued_in = q1 - COUNT_W'(sec_r);
            free_in   = free_ff + COUNT_W'(first_r) + COUNT_W'(sec_r);
         end
      endcase
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_kind;
         cnt_ff    <= req_chunk_count;
         busy_b_ff <= req_status_busy_b;
         st_a_ff   <= req_status_started_a;
         st_b_ff   <= req_status_started_b;
      end
   end

   // ring state update
   always_ff @(posedge clock) begin
      if (reset) begin
         queued_ff  <= '0;
         free_ff    <= FREE_RESET;
         head_ff    <= '0;
         tail_ff    <= '0;
         good_ff    <= 1'b0;
         user_ur_ff <= '0;
         irq_ur_ff  <= '0;
         hwm_ff     <= '0;
      end else if (cmd.execute) begin
         queued_ff  <= queued_in;
         free_ff    <= free_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         good_ff    <= good_in;
         user_ur_ff <= user_ur_in;
         irq_ur_ff  <= irq_ur_in;
         hwm_ff     <= hwm_in;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         acc_ff <= acc_in;
         ft_ff  <= ft_in;
         fr_ff  <= fr_in;
         fs_ff  <= fs_in;
         sv_ff  <= sv_in;
         sr_ff  <= sr_in;
         ss_ff  <= ss_in;
      end
   end

   assign rsp_accepted_chunks     = acc_ff;
   assign rsp_first_target        = ft_ff;
   assign rsp_first_from_ring     = fr_ff;
   assign rsp_first_slot          = 3'(fs_ff);
   assign rsp_second_valid        = sv_ff;
   assign rsp_second_from_ring    = sr_ff;
   assign rsp_second_slot         = 3'(ss_ff);
   assign rsp_user_underrun_total = user_ur_ff;
   assign rsp_irq_underrun_total  = irq_ur_ff;
   assign rsp_high_water          = hwm_ff;
   assign rsp_queued_chunks       = queued_ff;

endmodule

>>> src/ping_pong_dma_ring_feeder_unit.sv
// Top level of the ping-pong dma ring feeder.
// Depends on ppdrf_pkg, ppdrf_ctrl and ppdrf_datapath.
`timescale 1ns / 1ps

// A transfer is taken when start is high and busy is low. The block then
// stays busy while the datapath updates the ring counters, and the result
// appears on the rsp_ ports for exactly one cycle, marked by rsp_valid,
// once the controller has left its execute state. A new request may be
// accepted in that same cycle, while the result shows; no request is taken
// while busy is high, as set by the two-state controller (capture, then
// execute). The receiver cannot stall: it must take each result in the
// cycle that rsp_valid is high. Reset is synchronous; after it the ring is
// empty with ring depth minus two free slots.
module ping_pong_dma_ring_feeder_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_kind,
   input  logic [ppdrf_pkg::COUNT_W-1:0]   req_chunk_count,
   input  logic                            req_status_busy_b,
   input  logic                            req_status_started_a,
   input  logic                            req_status_started_b,
   output logic                            rsp_valid,
   output logic [ppdrf_pkg::COUNT_W-1:0]   rsp_accepted_chunks,
   output logic                            rsp_first_target,
   output logic                            rsp_first_from_ring,
   output logic [2:0]                      rsp_first_slot,
   output logic                            rsp_second_valid,
   output logic                            rsp_second_from_ring,
   output logic [2:0]                      rsp_second_slot,
   output logic [ppdrf_pkg::TOTAL_W-1:0]   rsp_user_underrun_total,
   output logic [ppdrf_pkg::TOTAL_W-1:0]   rsp_irq_underrun_total,
   output logic [ppdrf_pkg::COUNT_W-1:0]   rsp_high_water,
   output logic [ppdrf_pkg::COUNT_W-1:0]   rsp_queued_chunks
);
   import ppdrf_pkg::*;

   ctrl_cmd_type cmd;

   // controller
   ppdrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // datapath
   ppdrf_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .req_kind                (req_kind),
      .req_chunk_count         (req_chunk_count),
      .req_status_busy_b       (req_status_busy_b),
      .req_status_started_a    (req_status_started_a),
      .req_status_started_b    (req_status_started_b),
      .rsp_accepted_chunks     (rsp_accepted_chunks),
      .rsp_first_target        (rsp_first_target),
      .rsp_first_from_ring     (rsp_first_from_ring),
      .rsp_first_slot          (rsp_first_slot),
      .rsp_second_valid        (rsp_second_valid),
      .rsp_second_from_ring    (rsp_second_from_ring),
      .rsp_second_slot         (rsp_second_slot),
      .rsp_user_underrun_total (rsp_user_underrun_total),
      .rsp_irq_underrun_total  (rsp_irq_underrun_total),
      .rsp_high_water          (rsp_high_water),
      .rsp_queued_chunks       (rsp_queued_chunks)
   );

   // an accepted transfer makes the block busy next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not raise busy");

   // every busy cycle ends in exactly one result strobe
   assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && !busy))
      else $error("busy cycle not followed by a result");

   // a result strobe is always directly preceded by a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a transfer in flight");

   // the queue never holds more than the ring minus the two dma slots
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_queued_chunks <= FREE_RESET && rsp_high_water <= FREE_RESET))
      else $error("queued count beyond ring capacity");

endmodule

>>> bench/ping_pong_dma_ring_feeder_unit_tb.sv
// Self-checking testbench for the ping-pong dma ring feeder unit.
// Depends on ppdrf_pkg and ping_pong_dma_ring_feeder_unit; drives directed then random transfers.
`timescale 1ns / 1ps

module ping_pong_dma_ring_feeder_unit_tb;
   import ppdrf_pkg::*;

   localparam int RANDOM_ITEMS  = 1430;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 6;
   localparam int N_DIRECTED    = 21;

   // one refill decision as seen on the rsp_ ports
   typedef struct packed {
      logic [COUNT_W-1:0] accepted;
      logic               first_target;
      logic               first_from_ring;
      logic [2:0]         first_slot;
      logic               second_valid;
      logic               second_from_ring;
      logic [2:0]         second_slot;
      logic [TOTAL_W-1:0] user_total;
      logic [TOTAL_W-1:0] irq_total;
      logic [COUNT_W-1:0] high_water;
      logic [COUNT_W-1:0] queued;
   } refill_result_type;

   // directed stimulus row; want is only used when typed is set
   typedef struct {
      logic               kind;
      logic [COUNT_W-1:0] count;
      logic               busy_b;
      logic               started_a;
      logic               started_b;
      bit                 typed;
      refill_result_type  want;
   } stim_row_type;

   localparam refill_result_type NO_TYPED = refill_result_type'(0);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = KIND_WRITE;
   logic [COUNT_W-1:0] req_chunk_count = '0;
   logic req_status_busy_b = 1'b0;
   logic req_status_started_a = 1'b0;
   logic req_status_started_b = 1'b0;
   logic rsp_valid;
   logic [COUNT_W-1:0] rsp_accepted_chunks;
   logic rsp_first_target;
   logic rsp_first_from_ring;
   logic [2:0] rsp_first_slot;
   logic rsp_second_valid;
   logic rsp_second_from_ring;
   logic [2:0] rsp_second_slot;
   logic [TOTAL_W-1:0] rsp_user_underrun_total;
   logic [TOTAL_W-1:0] rsp_irq_underrun_total;
   logic [COUNT_W-1:0] rsp_high_water;
   logic [COUNT_W-1:0] rsp_queued_chunks;

   // predictor copy of the ring state
   int ring_queued;
   int ring_free;
   logic [2:0] ring_tail;
   logic flowing_flag;
   logic [TOTAL_W-1:0] user_underrun_count;
   logic [TOTAL_W-1:0] irq_underrun_count;
   logic [COUNT_W-1:0] ring_high_water;

   refill_result_type pending_refills[$];

   int error_count = 0;
   int items_sent = 0;
   int write_items = 0;
   int irq_items = 0;
   int results_checked = 0;
   int zero_page_refills = 0;
   int double_refills = 0;
   int full_ring_writes = 0;

   // directed table: reset state, full ring, oversized writes, every status combination,
   // underrun on empty queue, second refill from the zero page, slot wrap
   stim_row_type directed_table [N_DIRECTED] = '{
      '{KIND_IRQ,   4'd0,  1'b0, 1'b0, 1'b0, 1'b1,
        '{4'd0, DESC_A, 1'b0, 3'd0, 1'b1, 1'b0, 3'd0, 32'd0, 32'd1, 4'd0, 4'd0}},
      '{KIND_WRITE, 4'd15, 1'b0, 1'b0, 1'b0, 1'b1,
        '{4'd6, DESC_A, 1'b0, 3'd0, 1'b0, 1'b0, 3'd0, 32'd0, 32'd1, 4'd6, 4'd6}},
      '{KIND_WRITE, 4'd8,  1'b0, 1'b0, 1'b0, 1'b1,
        '{4'd0, DESC_A, 1'b0, 3'd0, 1'b0, 1'b0, 3'd0, 32'd0, 32'd1, 4'd6, 4'd6}},
      '{KIND_IRQ,   4'd0,  1'b1, 1'b1, 1'b1, 1'b0, NO_TYPED},
      '{KIND_IRQ,   4'd0,  1'b0, 1'b1, 1'b0, 1'b0, NO_TYPED},
      '{KIND_IRQ,   4'd0,  1'b1, 1'b0, 1'b0, 1'b0, NO_TYPED},
      '{KIND_IRQ,   4'd0,  1'b0, 1'b0, 1'b1, 1'b0, NO_TYPED},
      '{KIND_IRQ,   4'd0,  1'b1, 1'b1, 1'b0, 1'b0, NO_TYPED},
      '{KIND_IRQ,   4'd0,  1'b0, 1'b1, 1'b1, 1'b0, NO_TYPED},
      '{KIND_IRQ,   4'd0,  1'b0, 1'b0, 1'b0, 1'b0, NO_TYPED},
      '{KIND_WRITE, 4'd0,  1'b1, 1'b1, 1'b1, 1'b0, NO_TYPED},
      '{KIND_IRQ,   4'd0,  1'b1, 1'b0, 1'b1, 1'b0, NO_TYPED},
      '{KIND_WRITE, 4'd1,  1'b0, 1'b0, 1'b0, 1'b0, NO_TYPED},
      '{KIND_IRQ,   4'd0,  1'b0, 1'b0, 1'b0, 1'b0, NO_TYPED},
      '{KIND_IRQ,   4'd0,  1'b1, 1'b1, 1'b1, 1'b0, NO_TYPED},
      '{KIND_WRITE, 4'd3,  1'b0, 1'b0, 1'b0, 1'b0, NO_TYPED},
      '{KIND_WRITE, 4'd9,  1'b0, 1'b0, 1'b0, 1'b0, NO_TYPED},
      '{KIND_WRITE, 4'd15, 1'b1, 1'b1, 1'b1, 1'b0, NO_TYPED},
      '{KIND_IRQ,   4'd0,  1'b1, 1'b0, 1'b0, 1'b0, NO_TYPED},
      '{KIND_WRITE, 4'd2,  1'b0, 1'b0, 1'b0, 1'b0, NO_TYPED},
      '{KIND_IRQ,   4'd0,  1'b0, 1'b0, 1'b0, 1'b0, NO_TYPED}
   };

   ping_pong_dma_ring_feeder_unit DUT (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_kind                (req_kind),
      .req_chunk_count         (req_chunk_count),
      .req_status_busy_b       (req_status_busy_b),
      .req_status_started_a    (req_status_started_a),
      .req_status_started_b    (req_status_started_b),
      .rsp_valid               (rsp_valid),
      .rsp_accepted_chunks     (rsp_accepted_chunks),
      .rsp_first_target        (rsp_first_target),
      .rsp_first_from_ring     (rsp_first_from_ring),
      .rsp_first_slot          (rsp_first_slot),
      .rsp_second_valid        (rsp_second_valid),
      .rsp_second_from_ring    (rsp_second_from_ring),
      .rsp_second_slot         (rsp_second_slot),
      .rsp_user_underrun_total (rsp_user_underrun_total),
      .rsp_irq_underrun_total  (rsp_irq_underrun_total),
      .rsp_high_water          (rsp_high_water),
      .rsp_queued_chunks       (rsp_queued_chunks)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop in case the handshake hangs
   initial begin
      #5ms;
      $display("FAIL ping_pong_dma_ring_feeder_unit");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [TOTAL_W-1:0] got,
                                  input logic [TOTAL_W-1:0] want);
      error_count++;
      $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [TOTAL_W-1:0] got,
                              input logic [TOTAL_W-1:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   function automatic void reset_ring_model();
      ring_queued = 0;
      ring_free = RING_DEPTH - 2;
      ring_tail = '0;
      flowing_flag = 1'b0;
      user_underrun_count = '0;
      irq_underrun_count = '0;
      ring_high_water = '0;
   endfunction

   // one refill: oldest queued slot, or the zero page when the ring is empty
   function automatic void pop_ring_slot(output logic from_ring, output logic [2:0] slot);
      if (ring_queued == 0) begin
         from_ring = 1'b0;
         slot = '0;
      end else begin
         from_ring = 1'b1;
         slot = ring_tail;
         ring_tail = (int'(ring_tail) + 1 >= RING_DEPTH) ? 3'd0 : ring_tail + 3'd1;
         ring_queued--;
         ring_free++;
      end
   endfunction

   // next state and result of the ring for one transfer
   function automatic refill_result_type predict_refill(input logic kind,
                                                        input logic [COUNT_W-1:0] count,
                                                        input logic busy_b,
                                                        input logic started_a,
                                                        input logic started_b);
      refill_result_type r;
      logic a_first;
      int take;
      r = '0;
      if (kind == KIND_WRITE) begin
         take = (int'(count) < ring_free) ? int'(count) : ring_free;
         ring_free -= take;
         ring_queued += take;
         if (ring_queued > int'(ring_high_water)) ring_high_water = COUNT_W'(ring_queued);
         flowing_flag = 1'b1;
         r.accepted = COUNT_W'(take);
      end else begin
         a_first = (busy_b && started_b) || (!busy_b && !started_a);
         r.first_target = a_first ? DESC_A : DESC_B;
         pop_ring_slot(r.first_from_ring, r.first_slot);
         // only the first refill counts a drop out of good data
         if (!r.first_from_ring && flowing_flag) begin
            flowing_flag = 1'b0;
            user_underrun_count++;
         end
         if (a_first ? !started_b : !started_a) begin
            r.second_valid = 1'b1;
            irq_underrun_count++;
            pop_ring_slot(r.second_from_ring, r.second_slot);
         end
      end
      r.user_total = user_underrun_count;
      r.irq_total = irq_underrun_count;
      r.high_water = ring_high_water;
      r.queued = COUNT_W'(ring_queued);
      return r;
   endfunction

   // hold the request until the transfer is taken, then queue its expected result
   task automatic send_item(input logic kind, input logic [COUNT_W-1:0] count,
                            input logic busy_b, input logic started_a, input logic started_b,
                            input bit typed, input refill_result_type want);
      refill_result_type predicted;
      req_kind <= kind;
      req_chunk_count <= count;
      req_status_busy_b <= busy_b;
      req_status_started_a <= started_a;
      req_status_started_b <= started_b;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = predict_refill(kind, count, busy_b, started_a, started_b);
      pending_refills.push_back(typed ? want : predicted);
      items_sent++;
      if (kind == KIND_WRITE) begin
         write_items++;
         if (predicted.accepted == '0 && predicted.queued == COUNT_W'(RING_DEPTH - 2))
            full_ring_writes++;
      end else begin
         irq_items++;
         if (!predicted.first_from_ring) zero_page_refills++;
      end
   endtask

   // hold off until every outstanding result has come back
   task automatic wait_all_returned();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (pending_refills.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // result checker; results cannot be held off so every strobe is taken
   always @(posedge clock) begin
      refill_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_refills.size() == 0) begin
            report_mismatch("result with nothing pending", TOTAL_W'(rsp_queued_chunks), 0);
         end else begin
            want = pending_refills.pop_front();
            results_checked++;
            check_field("accepted_chunks", TOTAL_W'(rsp_accepted_chunks),
                        TOTAL_W'(want.accepted));
            check_field("first_target", TOTAL_W'(rsp_first_target),
                        TOTAL_W'(want.first_target));
            check_field("first_from_ring", TOTAL_W'(rsp_first_from_ring),
                        TOTAL_W'(want.first_from_ring));
            check_field("first_slot", TOTAL_W'(rsp_first_slot), TOTAL_W'(want.first_slot));
            check_field("second_valid", TOTAL_W'(rsp_second_valid),
                        TOTAL_W'(want.second_valid));
            check_field("second_from_ring", TOTAL_W'(rsp_second_from_ring),
                        TOTAL_W'(want.second_from_ring));
            check_field("second_slot", TOTAL_W'(rsp_second_slot), TOTAL_W'(want.second_slot));
            check_field("user_underrun_total", rsp_user_underrun_total, want.user_total);
            check_field("irq_underrun_total", rsp_irq_underrun_total, want.irq_total);
            check_field("high_water", TOTAL_W'(rsp_high_water), TOTAL_W'(want.high_water));
            check_field("queued_chunks", TOTAL_W'(rsp_queued_chunks), TOTAL_W'(want.queued));
            if (rsp_second_valid) double_refills++;
         end
      end
   end

   // stimulus
   initial begin
      int burst_len;
      int gap;
      int write_pct;
      int random_sent;
      bit mid_drain_done;
      logic kind;
      logic [COUNT_W-1:0] count;
      reset_ring_model();
      random_sent = 0;
      mid_drain_done = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_item(directed_table[i].kind, directed_table[i].count, directed_table[i].busy_b,
                   directed_table[i].started_a, directed_table[i].started_b,
                   directed_table[i].typed, directed_table[i].want);
      end
      wait_all_returned();

      // random bursts; the write share moves per burst so the ring fills and drains
      while (random_sent < RANDOM_ITEMS) begin
         burst_len = $urandom_range(1, 24);
         write_pct = $urandom_range(15, 85);
         for (int j = 0; j < burst_len && random_sent < RANDOM_ITEMS; j++) begin
            kind = ($urandom_range(0, 99) < write_pct) ? KIND_WRITE : KIND_IRQ;
            count = ($urandom_range(0, 9) < 7) ? COUNT_W'($urandom_range(0, 8))
                                                : COUNT_W'($urandom_range(0, 15));
            send_item(kind, count, 1'($urandom()), 1'($urandom()), 1'($urandom()),
                      1'b0, NO_TYPED);
            random_sent++;
         end
         // one full hold-off midway through the random part
         if (!mid_drain_done && random_sent >= RANDOM_ITEMS / 2) begin
            mid_drain_done = 1'b1;
            wait_all_returned();
         end else if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      // wind down
      wait_all_returned();
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (pending_refills.size() != 0) begin
         report_mismatch("result never arrived, queued_chunks", 0,
                         TOTAL_W'(pending_refills.pop_front().queued));
      end

      $display("covered %0d transfers (%0d writes, %0d interrupts), %0d results checked",
               items_sent, write_items, irq_items, results_checked);
      $display("double refills %0d, zero-page refills %0d, full-ring writes %0d, underruns %0d/%0d",
               double_refills, zero_page_refills, full_ring_writes,
               user_underrun_count, irq_underrun_count);
      if (error_count == 0) begin
         $display("PASS ping_pong_dma_ring_feeder_unit");
      end else begin
         $display("FAIL ping_pong_dma_ring_feeder_unit");
      end
      $finish;
   end

endmodule
